/* src/acld_pkg.sv */
// ----------------------------------------------------------------------------
// acld_pkg
// Shared types, codes and the line compare helper for the command line decoder.
// ----------------------------------------------------------------------------
package acld_pkg;

  // reply codes
  localparam logic [3:0] REPLY_NONE  = 4'd0;
  localparam logic [3:0] REPLY_START = 4'd1;
  localparam logic [3:0] REPLY_STOP  = 4'd2;
  localparam logic [3:0] REPLY_PONG  = 4'd3;
  localparam logic [3:0] REPLY_GYRO  = 4'd4;
  localparam logic [3:0] REPLY_ACCEL = 4'd5;
  localparam logic [3:0] REPLY_ERASE = 4'd6;
  localparam logic [3:0] REPLY_CALIB = 4'd7;
  localparam logic [3:0] REPLY_ERROR = 4'd8;

  // pending calibration codes
  localparam logic [2:0] CAL_NONE  = 3'd0;
  localparam logic [2:0] CAL_GYRO  = 3'd1;
  localparam logic [2:0] CAL_ACCEL = 3'd2;
  localparam logic [2:0] CAL_ERASE = 3'd3;
  localparam logic [2:0] CAL_CALIB = 3'd4;

  // operation codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TAKE = 1'b1;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  // longest word is 10 chars; one more byte is looked at for the terminator
  localparam int unsigned WORD_MAX  = 10;
  localparam int unsigned VIEW_MAX  = WORD_MAX + 1;

  localparam logic [79:0] W_START = "START";
  localparam logic [79:0] W_STOP  = "STOP";
  localparam logic [79:0] W_PING  = "PING";
  localparam logic [79:0] W_GYRO  = "CALIBGYRO";
  localparam logic [79:0] W_ACCEL = "CALIBACCEL";
  localparam logic [79:0] W_ERASE = "CALIBERASE";
  localparam logic [79:0] W_CALIB = "CALIB";

  typedef enum logic [1:0] {
    CLS_CHAR = 2'd0,
    CLS_CR   = 2'd1,
    CLS_LF   = 2'd2,
    CLS_TAKE = 2'd3
  } item_cls_t;

  typedef struct packed {
    item_cls_t  cls;
    logic [7:0] data;
  } item_t;

  // Line (byte 0 in low bits, missing bytes zero) cut at first zero byte
  // equals word. Word is a right-aligned string literal of wlen chars.
  function automatic logic word_match(input logic [8*VIEW_MAX-1:0] line,
                                      input logic [6:0]            len,
                                      input logic [79:0]           word,
                                      input logic [3:0]            wlen);
    logic       ok;
    logic [7:0] wb;
    logic [7:0] term;
    ok = (len >= {3'b000, wlen});
    for (int i = 0; i < WORD_MAX; i++) begin
      wb = 8'(word >> (8 * (int'(wlen) - i - 1)));
      if (i < int'(wlen)) begin
        ok = ok & (line[i*8 +: 8] == wb);
      end
    end
    term = 8'(line >> {wlen, 3'b000});
    ok = ok & ((len == {3'b000, wlen}) || (term == 8'h00));
    return ok;
  endfunction

endpackage

/* src/acld_front.sv */
// ----------------------------------------------------------------------------
// acld_front
// Classifies incoming requests into char / CR / LF / take and pushes them.
// ----------------------------------------------------------------------------
module acld_front (
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_operation,
  input  logic [7:0]     in_rx_byte,
  output logic           push,
  output acld_pkg::item_t push_item,
  input  logic           q_ready
);
  import acld_pkg::*;

  item_cls_t cls;

  always_comb begin
    if (in_operation == OP_TAKE) begin
      cls = CLS_TAKE;
    end else if (in_rx_byte == CHAR_CR) begin
      cls = CLS_CR;
    end else if (in_rx_byte == CHAR_LF) begin
      cls = CLS_LF;
    end else begin
      cls = CLS_CHAR;
    end
  end

  assign in_ready       = q_ready;
  assign push           = in_valid & q_ready;
  assign push_item.cls  = cls;
  assign push_item.data = in_rx_byte;

endmodule

/* src/acld_queue.sv */
// ----------------------------------------------------------------------------
// acld_queue
// Two-entry queue between the classifier and the line engine.
// ----------------------------------------------------------------------------
module acld_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  acld_pkg::item_t push_item,
  output logic            q_ready,
  input  logic            pop,
  output logic            q_valid,
  output acld_pkg::item_t q_item
);
  import acld_pkg::*;

  item_t      mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign q_ready = (count_r != 2'd2);
  assign q_valid = (count_r != 2'd0);
  assign q_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* src/acld_back.sv */
// ----------------------------------------------------------------------------
// acld_back
// Line store, word compare, stream/calibration state and result register.
// ----------------------------------------------------------------------------
module acld_back #(
  parameter int unsigned LINE_BUFFER_BYTES = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  acld_pkg::item_t q_item,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [3:0]      out_reply_code,
  output logic            out_streaming,
  output logic [2:0]      out_calib_command
);
  import acld_pkg::*;

  localparam int unsigned DEPTH = LINE_BUFFER_BYTES - 1;
  // only the bytes the compare can ever look at are kept
  localparam int unsigned CMP_N = (DEPTH < VIEW_MAX) ? DEPTH : VIEW_MAX;
  localparam int unsigned LEN_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(CMP_N);
  localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(DEPTH);
  localparam logic [LEN_W-1:0] CMP_L   = LEN_W'(CMP_N);

  logic [7:0]       store_r [CMP_N];
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             stream_r, stream_nxt;
  logic [2:0]       pend_r, pend_nxt;
  logic             ovalid_r, ovalid_nxt;
  logic [3:0]       reply_r, reply_nxt;
  logic             ostream_r;
  logic [2:0]       ocal_r, ocal_nxt;

  logic [8*VIEW_MAX-1:0] line_v;
  logic [6:0]            len7;
  logic                  wr_en;

  genvar g;
  generate
    for (g = 0; g < VIEW_MAX; g++) begin : g_view
      if (g < CMP_N) begin : g_have
        assign line_v[g*8 +: 8] = store_r[g];
      end else begin : g_none
        assign line_v[g*8 +: 8] = 8'h00;
      end
    end
  endgenerate

  assign len7 = 7'(len_r);
  assign pop  = q_valid & (~ovalid_r | out_ready);

  always_comb begin
    len_nxt    = len_r;
    stream_nxt = stream_r;
    pend_nxt   = pend_r;
    reply_nxt  = REPLY_NONE;
    ocal_nxt   = pend_r;
    wr_en      = 1'b0;
    unique case (q_item.cls)
      CLS_TAKE: begin
        ocal_nxt = pend_r;
        pend_nxt = CAL_NONE;
      end
      CLS_CR: begin
      end
      CLS_LF: begin
        len_nxt = '0;
        if (word_match(line_v, len7, W_START, 4'd5)) begin
          stream_nxt = 1'b1;
          reply_nxt  = REPLY_START;
        end else if (word_match(line_v, len7, W_STOP, 4'd4)) begin
          stream_nxt = 1'b0;
          reply_nxt  = REPLY_STOP;
        end else if (word_match(line_v, len7, W_PING, 4'd4)) begin
          reply_nxt = REPLY_PONG;
        end else if (word_match(line_v, len7, W_GYRO, 4'd9)) begin
          pend_nxt  = CAL_GYRO;
          reply_nxt = REPLY_GYRO;
        end else if (word_match(line_v, len7, W_ACCEL, 4'd10)) begin
          pend_nxt  = CAL_ACCEL;
          reply_nxt = REPLY_ACCEL;
        end else if (word_match(line_v, len7, W_ERASE, 4'd10)) begin
          pend_nxt  = CAL_ERASE;
          reply_nxt = REPLY_ERASE;
        end else if (word_match(line_v, len7, W_CALIB, 4'd5)) begin
          pend_nxt  = CAL_CALIB;
          reply_nxt = REPLY_CALIB;
        end else if (len_r != '0) begin
          reply_nxt = REPLY_ERROR;
        end
        ocal_nxt = pend_nxt;
      end
      CLS_CHAR: begin
        if (len_r < DEPTH_L) begin
          wr_en   = (len_r < CMP_L);
          len_nxt = len_r + 1'b1;
        end else begin
          len_nxt = '0;
        end
      end
      default: begin
      end
    endcase
    ovalid_nxt = pop | (ovalid_r & ~out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= '0;
      stream_r <= 1'b0;
      pend_r   <= CAL_NONE;
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
      if (pop) begin
        len_r    <= len_nxt;
        stream_r <= stream_nxt;
        pend_r   <= pend_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      reply_r   <= reply_nxt;
      ostream_r <= stream_nxt;
      ocal_r    <= ocal_nxt;
      if (wr_en) begin
        store_r[len_r[IDX_W-1:0]] <= q_item.data;
      end
    end
  end

  assign out_valid         = ovalid_r;
  assign out_reply_code    = reply_r;
  assign out_streaming     = ostream_r;
  assign out_calib_command = ocal_r;

endmodule

/* src/ascii_command_line_decoder_unit.sv */
// Path: an accepted request is written into the queue, and when the back pops it
//   its result is written into the result register, from which it can be taken.
// Throughput: one request per cycle while results are taken; the line engine handles
//   any request as it pops it, including the parallel word compare on a line feed.
// Reset (rst_n low, synchronous): line length, stream flag, pending calibration and
//   queue/result valid flags clear; line bytes keep whatever they held.
// ----------------------------------------------------------------------------
// ascii_command_line_decoder_unit
// Serial command line decoder: collects characters into a line and, on line
// feed, decodes START/STOP/PING/CALIB* commands into a reply code.
// ----------------------------------------------------------------------------
module ascii_command_line_decoder_unit #(
  parameter int unsigned LINE_BUFFER_BYTES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  // request channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_operation,
  input  logic [7:0] in_rx_byte,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_reply_code,
  output logic       out_streaming,
  output logic [2:0] out_calib_command
);
  import acld_pkg::*;

  // front -> queue
  logic  push;
  item_t push_item;
  logic  q_ready;
  // queue -> back
  logic  q_valid;
  item_t q_item;
  logic  pop;

  // Front: classify each request (char, CR, LF, take) and push it into
  // the queue; it stalls only when the queue is full.
  acld_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_rx_byte   (in_rx_byte),
    .push         (push),
    .push_item    (push_item),
    .q_ready      (q_ready)
  );

  // Two entries decouple the front from a stalled result port.
  acld_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .q_ready   (q_ready),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  // Back: owns the line bytes, length, stream flag and pending calibration.
  // It pops whenever the result register is free or being drained, so a
  // result taken in the same cycle does not hold up the next request; a
  // result left waiting stalls the back while the queue absorbs requests.
  acld_back #(
    .LINE_BUFFER_BYTES (LINE_BUFFER_BYTES)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_reply_code    (out_reply_code),
    .out_streaming     (out_streaming),
    .out_calib_command (out_calib_command)
  );

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ASCII command line decoder. An opening script
// covers the corner cases, then random command lines run through three
// idle/stall phases. Each result is checked against a typed or model reply.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import acld_pkg::*;

  localparam int unsigned LINE_BYTES    = 16;
  localparam int unsigned LINE_DEPTH    = LINE_BYTES - 1;
  localparam int unsigned SCRIPT_ROWS   = 28;
  localparam int unsigned RANDOM_ITEMS  = 700;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  // One result item, field for field as it leaves the block.
  typedef struct packed {
    logic [3:0] code;
    logic       stream;
    logic [2:0] calib;
  } reply_t;

  // Opening script row: a request plus, where it is obvious, its result.
  typedef struct packed {
    logic       op;
    logic [7:0] data;
    logic       known;
    reply_t     want;
  } script_row_t;

  localparam reply_t QUIET_REPLY = '{REPLY_NONE, 1'b0, CAL_NONE};
  localparam reply_t PONG_REPLY  = '{REPLY_PONG, 1'b0, CAL_NONE};
  localparam reply_t ERROR_REPLY = '{REPLY_ERROR, 1'b0, CAL_NONE};

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic       in_operation;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic [3:0] out_reply_code;
  logic       out_streaming;
  logic [2:0] out_calib_command;

  ascii_command_line_decoder_unit #(
    .LINE_BUFFER_BYTES(LINE_BYTES)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_reply_code   (out_reply_code),
    .out_streaming    (out_streaming),
    .out_calib_command(out_calib_command)
  );

  // --------------------------------------------------------------------------
  // Line model state: the bench's own copy of what the block should hold.
  // --------------------------------------------------------------------------
  logic [7:0]  line_bytes [LINE_DEPTH];
  int unsigned line_len;
  logic        stream_on;
  logic [2:0]  pending_cal;

  // Replies still owed by the block, oldest first.
  reply_t      owed_replies [$];

  int unsigned mismatches;
  int unsigned counted_requests;
  int unsigned cycle_count;
  int unsigned tx_gap_pct;
  int unsigned rx_stall_pct;

  string command_words [7] = '{"START", "STOP", "PING", "CALIBGYRO", "CALIBACCEL",
                               "CALIBERASE", "CALIB"};

  // Opening script. Row groups:
  //   take straight after reset, lone CR, LF on an empty line,
  //   a full 15-char line holding a zero byte and the byte extremes,
  //   a 16th char that throws the line away, then LF on the now empty line,
  //   PING followed by a zero byte (compare stops at the zero), and
  //   a junk line that must give the error reply.
  script_row_t opening_script [SCRIPT_ROWS] = '{
    '{OP_TAKE, 8'hFF, 1'b1, QUIET_REPLY},
    '{OP_BYTE, CHAR_CR, 1'b1, QUIET_REPLY},
    '{OP_BYTE, CHAR_LF, 1'b1, QUIET_REPLY},
    '{OP_BYTE, "C", 1'b0, QUIET_REPLY},
    '{OP_BYTE, "A", 1'b0, QUIET_REPLY},
    '{OP_BYTE, "L", 1'b0, QUIET_REPLY},
    '{OP_BYTE, "I", 1'b0, QUIET_REPLY},
    '{OP_BYTE, "B", 1'b0, QUIET_REPLY},
    '{OP_BYTE, 8'h00, 1'b0, QUIET_REPLY},
    '{OP_BYTE, 8'hFF, 1'b0, QUIET_REPLY},
    '{OP_BYTE, 8'h01, 1'b0, QUIET_REPLY},
    '{OP_BYTE, 8'h7F, 1'b0, QUIET_REPLY},
    '{OP_BYTE, 8'h80, 1'b0, QUIET_REPLY},
    '{OP_BYTE, "x", 1'b0, QUIET_REPLY},
    '{OP_BYTE, "y", 1'b0, QUIET_REPLY},
    '{OP_BYTE, "z", 1'b0, QUIET_REPLY},
    '{OP_BYTE, "~", 1'b0, QUIET_REPLY},
    '{OP_BYTE, " ", 1'b0, QUIET_REPLY},
    '{OP_BYTE, "Q", 1'b1, QUIET_REPLY},
    '{OP_BYTE, CHAR_LF, 1'b1, QUIET_REPLY},
    '{OP_BYTE, "P", 1'b0, QUIET_REPLY},
    '{OP_BYTE, "I", 1'b0, QUIET_REPLY},
    '{OP_BYTE, "N", 1'b0, QUIET_REPLY},
    '{OP_BYTE, "G", 1'b0, QUIET_REPLY},
    '{OP_BYTE, 8'h00, 1'b0, QUIET_REPLY},
    '{OP_BYTE, CHAR_LF, 1'b1, PONG_REPLY},
    '{OP_BYTE, 8'hFF, 1'b0, QUIET_REPLY},
    '{OP_BYTE, CHAR_LF, 1'b1, ERROR_REPLY}
  };

  // --------------------------------------------------------------------------
  // Line model
  // --------------------------------------------------------------------------

  // Stored line, cut at its first zero byte, equals the word.
  function automatic logic line_equals(input string word);
    int unsigned cut;
    logic        same;
    cut  = 0;
    same = 1'b1;
    while (cut < line_len && line_bytes[cut] != 8'h00) cut++;
    if (cut != word.len()) return 1'b0;
    for (int i = 0; i < int'(cut); i++) begin
      if (line_bytes[i] != word[i]) same = 1'b0;
    end
    return same;
  endfunction

  // Words are tried in the block's order, CALIB last; each compare is exact.
  function automatic logic [3:0] decode_line();
    if (line_equals("START")) begin
      stream_on = 1'b1;
      return REPLY_START;
    end
    if (line_equals("STOP")) begin
      stream_on = 1'b0;
      return REPLY_STOP;
    end
    if (line_equals("PING")) return REPLY_PONG;
    if (line_equals("CALIBGYRO")) begin
      pending_cal = CAL_GYRO;
      return REPLY_GYRO;
    end
    if (line_equals("CALIBACCEL")) begin
      pending_cal = CAL_ACCEL;
      return REPLY_ACCEL;
    end
    if (line_equals("CALIBERASE")) begin
      pending_cal = CAL_ERASE;
      return REPLY_ERASE;
    end
    if (line_equals("CALIB")) begin
      pending_cal = CAL_CALIB;
      return REPLY_CALIB;
    end
    // a zero-led line still counts as non-empty here
    if (line_len > 0) return REPLY_ERROR;
    return REPLY_NONE;
  endfunction

  // Advance the model by one accepted request and return its reply.
  function automatic reply_t predict_reply(input logic op, input logic [7:0] data);
    reply_t r;
    r.code = REPLY_NONE;
    if (op == OP_TAKE) begin
      r.calib     = pending_cal;
      pending_cal = CAL_NONE;
    end else begin
      if (data == CHAR_LF) begin
        r.code   = decode_line();
        line_len = 0;
      end else if (data != CHAR_CR) begin
        // CR falls through untouched
        if (line_len < LINE_DEPTH) begin
          line_bytes[line_len] = data;
          line_len++;
        end else begin
          // overflow: line dropped along with this char
          line_len = 0;
        end
      end
      r.calib = pending_cal;
    end
    r.stream = stream_on;
    return r;
  endfunction

  // Random byte that never ends or is skipped by the line logic.
  function automatic logic [7:0] line_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (c == CHAR_LF || c == CHAR_CR) c = 8'h00;
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Clock, cycle limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, changed on the falling edge.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // Every accepted result is matched against the oldest owed reply.
  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (owed_replies.size() == 0) begin
        $display("%0t: result with nothing owed: reply_code %0d streaming %0d calib %0d",
                 $time, out_reply_code, out_streaming, out_calib_command);
        mismatches++;
      end else begin
        want = owed_replies.pop_front();
        if (out_reply_code !== want.code) begin
          $display("%0t: reply_code expected %0d got %0d", $time, want.code, out_reply_code);
          mismatches++;
        end
        if (out_streaming !== want.stream) begin
          $display("%0t: streaming expected %0d got %0d", $time, want.stream, out_streaming);
          mismatches++;
        end
        if (out_calib_command !== want.calib) begin
          $display("%0t: calib_command expected %0d got %0d",
                   $time, want.calib, out_calib_command);
          mismatches++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Present one request from the falling edge on, with random idle cycles
  // ahead of it, and hold it until the block takes it. At the accepting
  // edge the model runs and the reply is queued (the typed one, if given).
  task automatic issue_request(input logic op, input logic [7:0] data,
                               input logic known, input reply_t want);
    reply_t model_reply;
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_rx_byte   <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    model_reply = predict_reply(op, data);
    owed_replies.push_back(known ? want : model_reply);
    // ignored CRs do not count toward the run length
    if (!(op == OP_BYTE && data == CHAR_CR)) counted_requests++;
  endtask

  task automatic issue_byte(input logic [7:0] data);
    issue_request(OP_BYTE, data, 1'b0, QUIET_REPLY);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    string       word;
    int          n;
    int          cr_at;
    int unsigned mutate;
    int unsigned pick;
    int unsigned k;

    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_operation     = OP_BYTE;
    in_rx_byte       = 8'h00;
    out_ready        = 1'b0;
    mismatches       = 0;
    counted_requests = 0;
    cycle_count      = 0;
    line_len         = 0;
    stream_on        = 1'b0;
    pending_cal      = CAL_NONE;
    tx_gap_pct       = 10;
    rx_stall_pct     = 48;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Opening script, run under the first idling phase.
    foreach (opening_script[i]) begin
      issue_request(opening_script[i].op, opening_script[i].data,
                    opening_script[i].known, opening_script[i].want);
    end

    // Random part. Mostly well-formed command lines with some damage,
    // mixed with takes, noise, overlong lines and bare line ends.
    while (counted_requests < SCRIPT_ROWS + RANDOM_ITEMS) begin
      // idling phases: sender light/receiver heavy, swapped, then none
      if (counted_requests < SCRIPT_ROWS + RANDOM_ITEMS / 3) begin
        tx_gap_pct   = 10;
        rx_stall_pct = 48;
      end else if (counted_requests < SCRIPT_ROWS + 2 * RANDOM_ITEMS / 3) begin
        tx_gap_pct   = 48;
        rx_stall_pct = 10;
      end else begin
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
      end

      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        word   = command_words[$urandom_range(0, 6)];
        n      = word.len();
        mutate = $urandom_range(0, 9);
        // near miss: a cut-short word
        if (mutate == 2) n = $urandom_range(1, n - 1);
        cr_at = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, n)) : -1;
        for (int i = 0; i < n; i++) begin
          if (i == cr_at) issue_byte(CHAR_CR);
          issue_byte(word[i]);
        end
        if (cr_at == n) issue_byte(CHAR_CR);
        if (mutate == 0) begin
          // zero byte and trailing junk: compare should still hit the word
          issue_byte(8'h00);
          k = $urandom_range(0, 4);
          repeat (k) issue_byte(line_char());
        end else if (mutate == 1) begin
          issue_byte(line_char());
        end
        issue_byte(CHAR_LF);
      end else if (pick < 70) begin
        issue_request(OP_TAKE, 8'($urandom_range(0, 255)), 1'b0, QUIET_REPLY);
      end else if (pick < 80) begin
        k = $urandom_range(1, 6);
        repeat (k) issue_byte(8'($urandom_range(0, 255)));
      end else if (pick < 90) begin
        // around the line limit, overflow included
        k = $urandom_range(LINE_DEPTH - 2, LINE_DEPTH + 3);
        repeat (k) issue_byte(line_char());
        issue_byte(CHAR_LF);
      end else begin
        issue_byte(($urandom_range(0, 1) == 0) ? CHAR_LF : CHAR_CR);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;

    // Drain, then a few quiet cycles to catch stray results.
    while (owed_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
src/acld_pkg.sv
src/acld_front.sv
src/acld_queue.sv
src/acld_back.sv
src/ascii_command_line_decoder_unit.sv
tb/sv/testbench.sv
